// File: sv/bqs_pkg.sv
// Shared types and constants for the quadratic Bezier segment generator.
package bqs_pkg;

  localparam int FRAC_BITS        = 24;
  localparam int DEF_MAX_SEGMENTS = 64;
  localparam int DEF_COORD_BITS   = 12;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_INIT,
    ST_EMIT
  } bqs_state_t;

  // Product terms formed by the shared multiplier
  typedef enum logic [1:0] {
    TERM_AX,   // a_x * dsq
    TERM_AY,   // a_y * dsq
    TERM_BX,   // (p1x - p0x) * delta
    TERM_BY    // (p1y - p0y) * delta
  } bqs_term_t;

  // Controller to datapath
  typedef struct packed {
    logic      load;
    bqs_term_t mul_term;
    logic      wr;
    bqs_term_t wr_term;
    logic      init;
    logic      step;
  } bqs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic span_short;
    logic last;
    logic out_free;
  } bqs_stat_t;

endpackage

// File: sv/bqs_ifs.sv
// Valid/ready channel interfaces for curve items and segment items.
interface bqs_in_if import bqs_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] control_x;
  logic [COORD_BITS-1:0] control_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;

  modport source (
    output valid, start_x, start_y, control_x, control_y, end_x, end_y,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, control_x, control_y, end_x, end_y,
    output ready
  );
endinterface

interface bqs_out_if import bqs_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] seg_from_x;
  logic [COORD_BITS-1:0] seg_from_y;
  logic [COORD_BITS-1:0] seg_to_x;
  logic [COORD_BITS-1:0] seg_to_y;
  logic                  last_segment;

  modport source (
    output valid, seg_from_x, seg_from_y, seg_to_x, seg_to_y, last_segment,
    input  ready
  );
  modport sink (
    input  valid, seg_from_x, seg_from_y, seg_to_x, seg_to_y, last_segment,
    output ready
  );
endinterface

// File: sv/bqs_ctrl.sv
// Controller state machine: setup sequencing and segment emission.
module bqs_ctrl import bqs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  bqs_stat_t stat,
  output bqs_cmd_t  cmd
);

  // cnt_r 0 lets the table registers settle, 1..4 multiply, 2..5 write back
  localparam logic [2:0] MUL_LAST = 3'd5;

  bqs_state_t state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.mul_term = TERM_AX;
    cmd.wr_term  = TERM_AX;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cnt_nxt  = '0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!stat.span_short) state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_term = bqs_term_t'(cnt_r[1:0] - 2'd1);
        cmd.wr       = (cnt_r >= 3'd2);
        cmd.wr_term  = bqs_term_t'(cnt_r[1:0] - 2'd2);
        cnt_nxt      = cnt_r + 3'd1;
        if (cnt_r == MUL_LAST) state_nxt = ST_INIT;
      end
      ST_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.step = 1'b1;
          if (stat.last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: sv/bqs_dp.sv
// Datapath: reciprocal tables, shared multiplier, difference accumulators, output register.
module bqs_dp import bqs_pkg::*; #(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int COORD_BITS   = DEF_COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bqs_cmd_t              cmd,
  output bqs_stat_t             stat,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] control_x,
  input  logic [COORD_BITS-1:0] control_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] seg_from_x,
  output logic [COORD_BITS-1:0] seg_from_y,
  output logic [COORD_BITS-1:0] seg_to_x,
  output logic [COORD_BITS-1:0] seg_to_y,
  output logic                  last_segment
);

  localparam int CB    = COORD_BITS;
  localparam int SEG_W = $clog2(MAX_SEGMENTS + 1);
  localparam int RW    = FRAC_BITS + 1;      // reciprocal, up to 1.0 in Q24
  localparam int AW    = CB + 2;             // p0 + p2 - 2*p1
  localparam int BW    = RW + 1;             // signed multiplier operand
  localparam int PW    = AW + BW;
  localparam int ACC_W = CB + FRAC_BITS + 8;

  // Reciprocal and squared reciprocal tables, built at elaboration
  logic [RW-1:0] recip_tab [0:MAX_SEGMENTS];
  logic [RW-1:0] dsq_tab   [0:MAX_SEGMENTS];

  assign recip_tab[0] = '0;
  assign dsq_tab[0]   = '0;

  for (genvar i = 1; i <= MAX_SEGMENTS; i++) begin : g_tab
    localparam longint RECIP = ((longint'(1) << FRAC_BITS) + i / 2) / i;
    localparam longint SQR   = (RECIP * RECIP) >> FRAC_BITS;
    assign recip_tab[i] = RW'(RECIP);
    assign dsq_tab[i]   = RW'(SQR);
  end

  // Pixel of an accumulator: clamp below zero and above full scale
  function automatic logic [CB-1:0] to_pix(input logic signed [ACC_W-1:0] v);
    logic [CB-1:0] p;
    if (v[ACC_W-1])                        p = '0;
    else if (|v[ACC_W-2:FRAC_BITS+CB])     p = '1;
    else                                   p = v[FRAC_BITS+CB-1:FRAC_BITS];
    return p;
  endfunction

  function automatic logic signed [ACC_W-1:0] ext_prod(input logic signed [PW-1:0] v);
    return {{(ACC_W-PW){v[PW-1]}}, v};
  endfunction

  // Segment count from the horizontal span
  logic signed [CB:0] span;
  logic [CB-1:0]      half;
  logic               span_short;
  logic [SEG_W-1:0]   seg_n;

  assign span       = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
  assign half       = span[CB:1];
  assign span_short = span[CB] || (half == '0);
  assign seg_n      = (half > CB'(MAX_SEGMENTS)) ? SEG_W'(MAX_SEGMENTS) : SEG_W'(half);

  // Second-difference and first-difference source terms
  logic signed [AW-1:0] ax_in, ay_in;
  logic signed [CB:0]   bx_in, by_in;

  assign ax_in = $signed({2'b00, start_x}) + $signed({2'b00, end_x})
               - $signed({1'b0, control_x, 1'b0});
  assign ay_in = $signed({2'b00, start_y}) + $signed({2'b00, end_y})
               - $signed({1'b0, control_y, 1'b0});
  assign bx_in = $signed({1'b0, control_x}) - $signed({1'b0, start_x});
  assign by_in = $signed({1'b0, control_y}) - $signed({1'b0, start_y});

  // Registers
  logic [CB-1:0]           p0x_r, p0y_r;
  logic signed [AW-1:0]    ax_r, ay_r;
  logic signed [CB:0]      bx_r, by_r;
  logic [SEG_W-1:0]        seg_n_r, rem_r;
  logic [RW-1:0]           delta_r, dsq_r;
  logic signed [PW-1:0]    prod_r, mx_r, my_r, kx_r, ky_r;
  logic signed [ACC_W-1:0] accx_r, accy_r, d1x_r, d1y_r, d2x_r, d2y_r;
  logic [CB-1:0]           prevx_r, prevy_r;
  logic                    out_vld_r, out_last_r;
  logic [CB-1:0]           out_fx_r, out_fy_r, out_tx_r, out_ty_r;

  // Multiplier operand selection
  logic signed [AW-1:0] op_a;
  logic signed [BW-1:0] op_b;

  always_comb begin
    case (cmd.mul_term)
      TERM_AX: begin op_a = ax_r;              op_b = $signed({1'b0, dsq_r});   end
      TERM_AY: begin op_a = ay_r;              op_b = $signed({1'b0, dsq_r});   end
      TERM_BX: begin op_a = {bx_r[CB], bx_r};  op_b = $signed({1'b0, delta_r}); end
      TERM_BY: begin op_a = {by_r[CB], by_r};  op_b = $signed({1'b0, delta_r}); end
      default: begin op_a = ax_r;              op_b = $signed({1'b0, dsq_r});   end
    endcase
  end

  // Next accumulator values for one segment
  logic signed [ACC_W-1:0] accx_nxt, accy_nxt;
  logic [CB-1:0]           pixx, pixy;

  assign accx_nxt = accx_r + d1x_r;
  assign accy_nxt = accy_r + d1y_r;
  assign pixx     = to_pix(accx_nxt);
  assign pixy     = to_pix(accy_nxt);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (cmd.load)      rem_r <= span_short ? '0 : seg_n;
      else if (cmd.step) rem_r <= rem_r - SEG_W'(1);
      if (cmd.step)          out_vld_r <= 1'b1;
      else if (out_ready)    out_vld_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    delta_r <= recip_tab[seg_n_r];
    dsq_r   <= dsq_tab[seg_n_r];
    prod_r  <= op_a * op_b;
    if (cmd.load) begin
      p0x_r   <= start_x;
      p0y_r   <= start_y;
      ax_r    <= ax_in;
      ay_r    <= ay_in;
      bx_r    <= bx_in;
      by_r    <= by_in;
      seg_n_r <= seg_n;
    end
    if (cmd.wr) begin
      case (cmd.wr_term)
        TERM_AX: mx_r <= prod_r;
        TERM_AY: my_r <= prod_r;
        TERM_BX: kx_r <= prod_r;
        TERM_BY: ky_r <= prod_r;
        default: mx_r <= prod_r;
      endcase
    end
    // d2 = 2*a*dsq, d1 = a*dsq + 2*b*delta, acc = p0 in Q24
    if (cmd.init) begin
      d2x_r   <= ext_prod(mx_r) <<< 1;
      d2y_r   <= ext_prod(my_r) <<< 1;
      d1x_r   <= ext_prod(mx_r) + (ext_prod(kx_r) <<< 1);
      d1y_r   <= ext_prod(my_r) + (ext_prod(ky_r) <<< 1);
      accx_r  <= $signed({{(ACC_W-CB-FRAC_BITS){1'b0}}, p0x_r, {FRAC_BITS{1'b0}}});
      accy_r  <= $signed({{(ACC_W-CB-FRAC_BITS){1'b0}}, p0y_r, {FRAC_BITS{1'b0}}});
      prevx_r <= p0x_r;
      prevy_r <= p0y_r;
    end
    if (cmd.step) begin
      accx_r     <= accx_nxt;
      accy_r     <= accy_nxt;
      d1x_r      <= d1x_r + d2x_r;
      d1y_r      <= d1y_r + d2y_r;
      prevx_r    <= pixx;
      prevy_r    <= pixy;
      out_fx_r   <= prevx_r;
      out_fy_r   <= prevy_r;
      out_tx_r   <= pixx;
      out_ty_r   <= pixy;
      out_last_r <= (rem_r == SEG_W'(1));
    end
  end

  // Status and outputs
  assign stat.span_short = span_short;
  assign stat.last       = (rem_r == SEG_W'(1));
  assign stat.out_free   = !out_vld_r || out_ready;

  assign out_valid    = out_vld_r;
  assign seg_from_x   = out_fx_r;
  assign seg_from_y   = out_fy_r;
  assign seg_to_x     = out_tx_r;
  assign seg_to_y     = out_ty_r;
  assign last_segment = out_last_r;

  // Checks
  a_step_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (!out_vld_r || out_ready))
    else $error("segment stepped while output register is held");

  a_step_rem: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (rem_r != '0))
    else $error("segment stepped with no segments remaining");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && rem_r == SEG_W'(1)) |=> (out_vld_r && out_last_r))
    else $error("final segment not flagged");

  a_rem_max: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= SEG_W'(MAX_SEGMENTS))
    else $error("segment count above limit");

endmodule

// File: sv/quadratic_bezier_segment_generator.sv
// Quadratic Bezier segment generator, top level.
// After a curve item is accepted, the shared setup multiplier forms four products and the
// accumulators are initialised; a curve with n segments (n = span/2 clamped to MAX_SEGMENTS)
// then emits one segment per cycle while the output is not held. No new curve is taken until
// its last segment is stepped. A curve whose span yields no segments produces nothing.
// Reset (synchronous, active low) returns the controller to idle and drops any pending segment.
module quadratic_bezier_segment_generator import bqs_pkg::*; #(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int COORD_BITS   = DEF_COORD_BITS
) (
  input logic       clk,
  input logic       rst_n,
  bqs_in_if.sink    in_ch,
  bqs_out_if.source out_ch
);

  bqs_cmd_t  cmd;
  bqs_stat_t stat;

  bqs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bqs_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .COORD_BITS   (COORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .start_x      (in_ch.start_x),
    .start_y      (in_ch.start_y),
    .control_x    (in_ch.control_x),
    .control_y    (in_ch.control_y),
    .end_x        (in_ch.end_x),
    .end_y        (in_ch.end_y),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .seg_from_x   (out_ch.seg_from_x),
    .seg_from_y   (out_ch.seg_from_y),
    .seg_to_x     (out_ch.seg_to_x),
    .seg_to_y     (out_ch.seg_to_y),
    .last_segment (out_ch.last_segment)
  );

endmodule
